/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

/* hdl/sldf_pkg.sv */
// ----------------------------------------------------------------------------
// sldf_pkg
// Types and constants of the sync/length frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sldf_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int IDX_W  = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_LENGTH  = 2'd2;

  // reset values
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hAA;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST  = 6'd32;

  // largest length a 6-bit header field can carry
  localparam int LEN_FIELD_MAX = 63;

  typedef enum logic [4:0] {
    ST_HUNT    = 5'b00001,
    ST_SECOND  = 5'b00010,
    ST_LENGTH  = 5'b00100,
    ST_PAYLOAD = 5'b01000,
    ST_DRAIN   = 5'b10000
  } state_t;

endpackage

`default_nettype wire

/* hdl/sync_length_frame_deframer_core.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_core
// Two-byte sync, length-prefixed frame deframer with a payload memory.
// ----------------------------------------------------------------------------
// Each received byte is taken while the block is parsing and its result
// register is free or being emptied. Once the last payload byte of an
// N-byte frame arrives, the block stops taking bytes and drains the frame
// from its payload memory: N results, each fetched by a registered read of
// that memory and held there while the sink stalls. A zero-length header
// yields one empty result at once. A byte is not taken while a result sits
// unaccepted in the output register.
`default_nettype none

`include "assert_macros.svh"

module sync_length_frame_deframer_core
  import sldf_pkg::*;
#(
  parameter int MAX_FRAME = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [BYTE_W-1:0] cfg_data,
  // received bytes
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] rx_byte
  // frame results
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [15:0]            m_tdata,   // [7:0] payload_byte, [13:8] frame_length
  output logic                   m_tlast,   // last_of_frame
  output logic                   m_tuser    // empty_frame
);

  localparam int ADDR_W = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam logic [BYTE_W-1:0] LIMIT_CAP =
    (MAX_FRAME > LEN_FIELD_MAX) ? BYTE_W'(LEN_FIELD_MAX) : BYTE_W'(MAX_FRAME);
  localparam logic [8:0] FRAME_DEPTH = 9'(MAX_FRAME);

  // configuration registers
  logic [BYTE_W-1:0] sync_first;
  logic [BYTE_W-1:0] sync_second;
  logic [LEN_W-1:0]  max_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
      max_length  <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_FIRST:  sync_first  <= cfg_data;
        REG_SYNC_SECOND: sync_second <= cfg_data;
        REG_MAX_LENGTH:  max_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  state_t            state;
  logic [LEN_W-1:0]  expected_length;
  logic [LEN_W-1:0]  bytes_collected;
  logic [LEN_W-1:0]  rd_idx;
  logic [LEN_W-1:0]  ld_idx;
  logic              rd_pend;

  // output register
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic [LEN_W-1:0]  out_len;
  logic              out_last;
  logic              out_empty;

  // payload memory
  logic [BYTE_W-1:0] mem [MAX_FRAME];
  logic [BYTE_W-1:0] rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              rd_issue;
  logic              load;

  logic              in_xfer;
  logic              out_free;
  logic [BYTE_W-1:0] len_limit;
  logic [LEN_W-1:0]  collected_next;
  logic              len_ok;
  logic              empty_hdr;
  logic              is_drain;

  assign out_free  = !out_valid || m_tready;
  assign is_drain  = (state == ST_DRAIN);
  assign s_tready  = !is_drain && out_free;
  assign in_xfer   = s_tvalid && s_tready;

  assign len_limit = ({2'b00, max_length} > LIMIT_CAP) ? LIMIT_CAP : {2'b00, max_length};
  assign len_ok    = (s_tdata <= len_limit);
  assign empty_hdr = in_xfer && (state == ST_LENGTH) && len_ok && (s_tdata == '0);
  assign collected_next = bytes_collected + LEN_W'(1);

  assign mem_we    = in_xfer && (state == ST_PAYLOAD) &&
                     ({3'b000, bytes_collected} < FRAME_DEPTH);
  assign mem_waddr = ADDR_W'(bytes_collected);

  // drain: one read in flight, held in rd_data until the output takes it
  assign load      = rd_pend && out_free;
  assign rd_issue  = is_drain && (rd_idx < expected_length) && (!rd_pend || load);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_data <= mem[ADDR_W'(rd_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_HUNT;
      expected_length <= '0;
      bytes_collected <= '0;
      rd_idx          <= '0;
      ld_idx          <= '0;
      rd_pend         <= 1'b0;
    end else begin
      case (state)
        ST_HUNT: begin
          if (in_xfer && (s_tdata == sync_first)) begin
            state <= ST_SECOND;
          end
        end
        ST_SECOND: begin
          if (in_xfer) begin
            state <= (s_tdata == sync_second) ? ST_LENGTH : ST_HUNT;
          end
        end
        ST_LENGTH: begin
          if (in_xfer) begin
            if (!len_ok) begin
              state <= ST_HUNT;
            end else if (s_tdata == '0) begin
              state           <= ST_HUNT;
              expected_length <= '0;
              bytes_collected <= '0;
            end else begin
              state           <= ST_PAYLOAD;
              expected_length <= s_tdata[LEN_W-1:0];
              bytes_collected <= '0;
            end
          end
        end
        ST_PAYLOAD: begin
          if (in_xfer) begin
            bytes_collected <= collected_next;
            if (collected_next >= expected_length) begin
              state   <= ST_DRAIN;
              rd_idx  <= '0;
              ld_idx  <= '0;
              rd_pend <= 1'b0;
            end
          end
        end
        ST_DRAIN: begin
          if (rd_issue) begin
            rd_idx <= rd_idx + LEN_W'(1);
          end
          if (rd_issue) begin
            rd_pend <= 1'b1;
          end else if (load) begin
            rd_pend <= 1'b0;
          end
          if (load) begin
            ld_idx <= ld_idx + LEN_W'(1);
            if ((ld_idx + LEN_W'(1)) == expected_length) begin
              state           <= ST_HUNT;
              bytes_collected <= '0;
            end
          end
        end
        default: begin
          state <= ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load || empty_hdr) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= rd_data;
      out_len   <= expected_length;
      out_last  <= ((ld_idx + LEN_W'(1)) == expected_length);
      out_empty <= 1'b0;
    end else if (empty_hdr) begin
      out_byte  <= '0;
      out_len   <= '0;
      out_last  <= 1'b1;
      out_empty <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_len, out_byte};
  assign m_tlast  = out_last;
  assign m_tuser  = out_empty;

  // checks
  `ASSERT_IMPL(a_pend_only_drain, rd_pend, is_drain, "read pending outside drain")
  `ASSERT_IMPL(a_read_count, is_drain, rd_idx == (ld_idx + LEN_W'(rd_pend)), "drain counters out of step")
  `ASSERT_IMPL(a_drain_ends_last, $past(!rst) && $past(is_drain) && !is_drain, m_tvalid && m_tlast, "drain ended without last result")
  `ASSERT_IMPL(a_nonempty_len, m_tvalid && !m_tuser, m_tdata[13:8] != '0, "payload result with zero length")

endmodule

`default_nettype wire

/* sim/sync_length_frame_deframer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_core_tb
// Self-checking bench for the sync/length frame deframer.
// ----------------------------------------------------------------------------
// Received bytes are streamed in and every frame result is checked against a
// behavioral deframer kept in step with the accepted bytes. A short table
// covers sync misses, length limits, empty and one-byte frames. Random
// phases follow, each with its own register setting and mix of source idle
// and sink stall.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer_core_tb;
  import sldf_pkg::*;

  localparam int FRAME_CAP      = 32;
  localparam int DRAIN_GAP      = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES    = 10;
  localparam int DIR_ROWS       = 23;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    P_HUNT,
    P_SECOND,
    P_LENGTH,
    P_PAYLOAD
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] payload;
    logic [5:0] len;
    logic       last;
    logic       empty;
  } frame_beat_t;

  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    frame_beat_t beat;
  } dir_row_t;

  localparam frame_beat_t NO_BEAT    = '0;
  localparam frame_beat_t EMPTY_BEAT = '{8'h00, 6'd0, 1'b1, 1'b1};
  localparam frame_beat_t ONE_BEAT   = '{8'hFF, 6'd1, 1'b1, 1'b0};

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty frame
    '{SYNC_FIRST_RST,  1'b0, NO_BEAT},
    '{SYNC_SECOND_RST, 1'b0, NO_BEAT},
    '{8'h00,           1'b1, EMPTY_BEAT},
    // repeated first sync byte counts as a wrong second byte
    '{SYNC_FIRST_RST,  1'b0, NO_BEAT},
    '{SYNC_FIRST_RST,  1'b0, NO_BEAT},
    '{SYNC_SECOND_RST, 1'b0, NO_BEAT},
    '{8'h00,           1'b0, NO_BEAT},
    // one over the length limit, then noise
    '{SYNC_FIRST_RST,  1'b0, NO_BEAT},
    '{SYNC_SECOND_RST, 1'b0, NO_BEAT},
    '{8'd33,           1'b0, NO_BEAT},
    '{8'hFF,           1'b0, NO_BEAT},
    // largest header byte
    '{SYNC_FIRST_RST,  1'b0, NO_BEAT},
    '{SYNC_SECOND_RST, 1'b0, NO_BEAT},
    '{8'hFF,           1'b0, NO_BEAT},
    // one-byte frame
    '{SYNC_FIRST_RST,  1'b0, NO_BEAT},
    '{SYNC_SECOND_RST, 1'b0, NO_BEAT},
    '{8'd1,            1'b0, NO_BEAT},
    '{8'hFF,           1'b1, ONE_BEAT},
    // two-byte frame
    '{SYNC_FIRST_RST,  1'b0, NO_BEAT},
    '{SYNC_SECOND_RST, 1'b0, NO_BEAT},
    '{8'd2,            1'b0, NO_BEAT},
    '{8'h00,           1'b0, NO_BEAT},
    '{8'h80,           1'b0, NO_BEAT}
  };

  logic              clk;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [BYTE_W-1:0] cfg_data  = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [15:0]       m_tdata;
  logic              m_tlast;
  logic              m_tuser;

  // register mirror
  logic [7:0] cur_sync_first  = SYNC_FIRST_RST;
  logic [7:0] cur_sync_second = SYNC_SECOND_RST;
  logic [5:0] cur_max_length  = MAX_LENGTH_RST;

  // deframer state
  parse_phase_t hunt_phase = P_HUNT;
  int           hdr_length = 0;
  int           payload_count = 0;
  logic [7:0]   payload_mem [FRAME_CAP];
  frame_beat_t  burst [FRAME_CAP];

  frame_beat_t pending_beats [$];

  int send_idle_pct  = 0;
  int sink_stall_pct = 0;
  int mismatches     = 0;
  int bytes_sent     = 0;
  int results_seen   = 0;
  int frames_seen    = 0;
  int empties_seen   = 0;

  sync_length_frame_deframer_core #(
    .MAX_FRAME(FRAME_CAP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic int length_cap();
    return (cur_max_length > FRAME_CAP) ? FRAME_CAP : int'(cur_max_length);
  endfunction

  // Advance the deframer by one byte; fill burst and return the result count.
  function automatic int deframe_byte(input logic [7:0] rx);
    int n;
    n = 0;
    case (hunt_phase)
      P_HUNT: begin
        if (rx == cur_sync_first) hunt_phase = P_SECOND;
      end
      P_SECOND: begin
        hunt_phase = (rx == cur_sync_second) ? P_LENGTH : P_HUNT;
      end
      P_LENGTH: begin
        if (int'(rx) > length_cap()) begin
          hunt_phase = P_HUNT;
        end else if (rx == 8'd0) begin
          hunt_phase = P_HUNT;
          burst[0] = EMPTY_BEAT;
          n = 1;
        end else begin
          hdr_length = int'(rx);
          payload_count = 0;
          hunt_phase = P_PAYLOAD;
        end
      end
      default: begin
        payload_mem[payload_count] = rx;
        payload_count++;
        if (payload_count == hdr_length) begin
          for (int i = 0; i < hdr_length; i++)
            burst[i] = '{payload_mem[i], hdr_length[5:0], i == hdr_length - 1, 1'b0};
          n = hdr_length;
          payload_count = 0;
          hunt_phase = P_HUNT;
        end
      end
    endcase
    return n;
  endfunction

  // Offer one byte; on its transfer queue the beats it produces.
  task automatic send_byte(input logic [7:0] rx, input logic typed = 1'b0,
                           input frame_beat_t beat = '0);
    int n;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rx;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    n = deframe_byte(rx);
    if (typed) begin
      pending_beats.push_back(beat);
    end else begin
      for (int i = 0; i < n; i++) pending_beats.push_back(burst[i]);
    end
  endtask

  task automatic send_frame(input int len);
    send_byte(cur_sync_first);
    send_byte(cur_sync_second);
    send_byte(len[7:0]);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
  endtask

  // Hold the source until every queued beat has been delivered.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Leaves cfg_we high; callers lower it after the last write.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SYNC_FIRST:  cur_sync_first  = data;
      REG_SYNC_SECOND: cur_sync_second = data;
      REG_MAX_LENGTH:  cur_max_length  = data[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [7:0] first, input logic [7:0] second,
                              input logic [7:0] max_len);
    write_reg(REG_SYNC_FIRST, first);
    write_reg(REG_SYNC_SECOND, second);
    write_reg(REG_MAX_LENGTH, max_len);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed frames, with noise, sync misses and oversize headers.
  task automatic run_phase(input int target);
    int sent;
    int kind;
    int lim;
    int len;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(9);
      lim  = length_cap();
      if (kind <= 6) begin
        len = ($urandom_range(7) == 0) ? lim : $urandom_range((lim < 6) ? lim : 6);
        send_frame(len);
        sent += len + 3;
      end else if (kind == 7) begin
        repeat ($urandom_range(3, 1)) begin
          send_byte(8'($urandom_range(255)));
          sent++;
        end
      end else if (kind == 8) begin
        send_byte(cur_sync_first);
        send_byte(8'($urandom_range(255)));
        sent += 2;
      end else begin
        send_byte(cur_sync_first);
        send_byte(cur_sync_second);
        send_byte(8'($urandom_range(255, lim + 1)));
        sent += 3;
      end
    end
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : check_results
    frame_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tlast) frames_seen++;
      if (m_tuser) empties_seen++;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected result data=%h last=%b empty=%b",
                                  m_tdata, m_tlast, m_tuser));
      end else begin
        want = pending_beats.pop_front();
        if (m_tdata[7:0] !== want.payload || m_tdata[13:8] !== want.len ||
            m_tlast !== want.last || m_tuser !== want.empty)
          report_mismatch($sformatf(
            "byte %h/%h len %0d/%0d last %b/%b empty %b/%b (got/expected)",
            m_tdata[7:0], want.payload, m_tdata[13:8], want.len,
            m_tlast, want.last, m_tuser, want.empty));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(DIR_TABLE[i].rx, DIR_TABLE[i].typed, DIR_TABLE[i].beat);
    quiesce();

    // extreme sync bytes, full-size frame, no idling
    program_regs(8'h00, 8'hFF, 8'd32);
    send_frame(FRAME_CAP);
    run_phase(PHASE_BYTES);
    quiesce();

    // only empty frames pass, source idles
    program_regs(8'hFF, 8'h00, 8'd0);
    send_idle_pct = 77;
    run_phase(PHASE_BYTES);
    quiesce();

    // equal sync bytes, wide write masks to a limit of 5, sink stalls
    program_regs(8'h3C, 8'h3C, 8'hC5);
    send_idle_pct  = 0;
    sink_stall_pct = 77;
    run_phase(PHASE_BYTES);
    quiesce();

    // unused index is dropped; limit 63 clips to the frame capacity
    write_reg(REG_UNUSED, 8'($urandom_range(255)));
    program_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 8'hFF);
    send_idle_pct  = 34;
    sink_stall_pct = 34;
    run_phase(PHASE_BYTES);
    quiesce();

    if (pending_beats.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_beats.size()));

    $display("covered %0d received bytes and %0d results in %0d frames (%0d empty)",
             bytes_sent, results_seen, frames_seen, empties_seen);
    $display("five register settings, idle mixes none/source/sink/both, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
